>>> rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and command/status types for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int unsigned DEF_MAX_FRAMES = 65536;
    localparam int unsigned DEF_PAGE_BITS  = 12;

    localparam int unsigned CFG_W   = 17;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned FADDR_W = 28;
    localparam int unsigned FREE_W  = 17;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_RESERVE = 2'd3;

    typedef struct packed {
        logic clear;
        logic start;
        logic wr;
        logic done;
    } bfa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_alloc;
        logic word_last;
    } bfa_status_t;

endpackage

>>> rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/bfa_datapath.sv
// ----------------------------------------------------------------------------
// bfa_datapath
// Frame range arithmetic, map word walk, free count and result registers.
// ----------------------------------------------------------------------------
module bfa_datapath #(
    parameter int unsigned MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES,
    parameter int unsigned PAGE_BITS  = bfa_pkg::DEF_PAGE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfa_pkg::bfa_cmd_t             cmd,
    output bfa_pkg::bfa_status_t          status,
    input  logic [bfa_pkg::CFG_W-1:0]     frame_count_reg_in,
    input  logic [1:0]                    operation,
    input  logic [bfa_pkg::ADDR_W-1:0]    address,
    input  logic [bfa_pkg::ADDR_W-1:0]    length,
    output logic [bfa_pkg::FADDR_W-1:0]   frame_address,
    output logic                          success,
    output logic [bfa_pkg::FREE_W-1:0]    free_total
);
    import bfa_pkg::*;

    localparam int unsigned WORDS = (MAX_FRAMES + 63) / 64;
    localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned FR_W  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned E_W   = ADDR_W + 2;
    localparam int unsigned CNT_W = FR_W + 1;
    localparam logic [E_W-1:0] PAGE_M1 = E_W'((64'd1 << PAGE_BITS) - 1);

    logic [1:0]        op_reg;
    logic [FR_W-1:0]   start_reg, end_reg;
    logic [WA_W-1:0]   word_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ok_reg, found_reg;
    logic [FADDR_W-1:0] faddr_reg;

    logic [63:0]       rd_data, wr_data;
    logic [WA_W-1:0]   rd_addr;

    // range computation
    logic [E_W-1:0] a_e, l_e, s_full, e_full, lim;
    logic [FR_W-1:0] s_fr, e_fr;
    always_comb
    begin
        a_e = E_W'(address);
        l_e = E_W'(length);
        lim = (E_W'(frame_count_reg_in) > E_W'(MAX_FRAMES)) ? E_W'(MAX_FRAMES)
                                                              : E_W'(frame_count_reg_in);
        case (operation)
            OP_RELEASE:
            begin
                s_full = (a_e + PAGE_M1) >> PAGE_BITS;
                e_full = (a_e + l_e) >> PAGE_BITS;
            end
            OP_RESERVE:
            begin
                s_full = a_e >> PAGE_BITS;
                e_full = (a_e + l_e + PAGE_M1) >> PAGE_BITS;
            end
            OP_FREE:
            begin
                s_full = a_e >> PAGE_BITS;
                e_full = (a_e >> PAGE_BITS) + E_W'(1);
            end
            default:
            begin
                s_full = '0;
                e_full = lim;
            end
        endcase
        if (e_full > lim)
        begin
            e_full = lim;
        end
        if (s_full > e_full)
        begin
            s_full = e_full;
        end
        s_fr = FR_W'(s_full);
        e_fr = FR_W'(e_full);
    end

    // per-word mask of frames in [start,end)
    logic [FR_W-1:0] wbase;
    logic [FR_W-1:0] alloc_idx;
    logic [63:0]     mask, set_mask, clr_mask, low_free;
    logic [6:0]      n_set, n_clr;
    logic            any_free;
    logic [5:0]      free_pos;
    always_comb
    begin
        wbase = FR_W'({word_reg, 6'd0});
        for (int i = 0; i < 64; i++)
        begin
            mask[i] = ((wbase + FR_W'(i)) >= start_reg) && ((wbase + FR_W'(i)) < end_reg)
                      && ((FR_W + 1)'(wbase) + (FR_W + 1)'(i) < (FR_W + 1)'(end_reg));
        end
        low_free = ~rd_data & mask;
        any_free = |low_free;
        free_pos = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (low_free[i])
            begin
                free_pos = 6'(i);
            end
        end
        alloc_idx = wbase + FR_W'(free_pos);
        set_mask = '0;
        clr_mask = '0;
        case (op_reg)
            OP_ALLOC:
            begin
                set_mask = (any_free && !found_reg) ? (64'd1 << free_pos) : '0;
            end
            OP_RESERVE:
            begin
                set_mask = ~rd_data & mask;
            end
            default:
            begin
                clr_mask = rd_data & mask;
            end
        endcase
        wr_data = (rd_data | set_mask) & ~clr_mask;
        n_set = 7'($countones(set_mask));
        n_clr = 7'($countones(clr_mask));
    end

    assign rd_addr = cmd.start ? WA_W'(s_fr >> 6) : word_reg;

    bfa_ram #(.WIDTH(64), .DEPTH(WORDS)) u_map (
        .clk     (clk),
        .wr_en   (cmd.wr | cmd.clear),
        .wr_addr (word_reg),
        .wr_data (cmd.clear ? '1 : wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            cnt_reg   <= '0;
            op_reg    <= OP_ALLOC;
            start_reg <= '0;
            end_reg   <= '0;
            ok_reg    <= 1'b0;
            found_reg <= 1'b0;
            faddr_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                word_reg <= word_reg + WA_W'(1);
            end
            else if (cmd.start)
            begin
                op_reg    <= operation;
                start_reg <= s_fr;
                end_reg   <= e_fr;
                word_reg  <= WA_W'(s_fr >> 6);
                ok_reg    <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.wr)
            begin
                cnt_reg <= cnt_reg + CNT_W'(n_clr) - CNT_W'(n_set);
                if ((n_set != 7'd0) || (n_clr != 7'd0))
                begin
                    ok_reg <= 1'b1;
                end
                if (op_reg == OP_ALLOC && any_free && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                word_reg <= word_reg + WA_W'(1);
            end
            if (cmd.done)
            begin
                faddr_reg <= (op_reg == OP_ALLOC && any_free && !found_reg)
                             ? FADDR_W'({{FADDR_W{1'b0}}, alloc_idx} << PAGE_BITS) : '0;
            end
        end
    end

    logic [FR_W-1:0] last_frame;
    assign last_frame = FR_W'({word_reg, 6'd0}) + FR_W'(64);
    assign status.clear_last  = (word_reg == WA_W'(WORDS - 1));
    assign status.is_alloc    = (op_reg == OP_ALLOC);
    assign status.word_last   = (last_frame >= end_reg) || (word_reg == WA_W'(WORDS - 1))
                                || (op_reg == OP_ALLOC && any_free);

    assign frame_address = faddr_reg;
    assign success       = ok_reg;
    assign free_total    = (cnt_reg > CNT_W'(17'h1FFFF)) ? 17'h1FFFF : FREE_W'(cnt_reg);

endmodule

>>> rtl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: clearing pass after reset, then read/modify/write word walk.
// ----------------------------------------------------------------------------
module bfa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  bfa_pkg::bfa_status_t status,
    output bfa_pkg::bfa_cmd_t    cmd
);
    import bfa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr = 1'b1;
                if (status.word_last)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> in_stall) else $error("input taken mid-walk");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (state_reg == S_IDLE)) else $error("start outside idle");

endmodule

>>> rtl/bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// Bitmap page-frame allocator: allocate, free, release and reserve regions.
//
//  channel | signals                                 | flow
//  cfg     | cfg_valid cfg_ready frame_count          | write frame_count
//  in      | in_valid in_stall operation address len  | one operation
//  out     | out_valid out_stall frame_address ...    | one result
//
// After reset a clearing pass writes every map word and marks every frame used.
// Each map word walked takes a read state and a write state: allocate
// walks from word 0 up to the first free frame, regions walk the words
// they touch. One item is held at a time.
// A stalled result holds the block; input stays stalled until it transfers.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top #(
    parameter int unsigned MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES,
    parameter int unsigned PAGE_BITS  = bfa_pkg::DEF_PAGE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]     frame_count,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [bfa_pkg::ADDR_W-1:0]    address,
    input  logic [bfa_pkg::ADDR_W-1:0]    length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bfa_pkg::FADDR_W-1:0]   frame_address,
    output logic                          success,
    output logic [bfa_pkg::FREE_W-1:0]    free_total
);
    import bfa_pkg::*;

    logic [CFG_W-1:0] frame_count_reg;
    bfa_cmd_t         cmd;
    bfa_status_t      status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_count_reg <= frame_count;
        end
    end

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bfa_datapath #(.MAX_FRAMES(MAX_FRAMES), .PAGE_BITS(PAGE_BITS)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .frame_count_reg_in (frame_count_reg),
        .operation          (operation),
        .address            (address),
        .length             (length),
        .frame_address      (frame_address),
        .success            (success),
        .free_total         (free_total)
    );

endmodule
